// ===== rtl/sqmm_pkg.sv =====
// Shared constants for the square matrix multiplier.
`default_nettype none
package sqmm_pkg;

  // Action codes of an input transaction
  localparam logic [1:0] ACT_LOAD_LEFT  = 2'd0;
  localparam logic [1:0] ACT_LOAD_RIGHT = 2'd1;
  localparam logic [1:0] ACT_COMPUTE    = 2'd2;

  // Matrix geometry and number format
  localparam int DIM_DEFAULT = 4;
  localparam int DATA_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int INDEX_W     = 2;

endpackage
`default_nettype wire

// ===== rtl/square_matrix_multiply.sv =====
// Square matrix multiplier: two element stores, a multiply-accumulate sequencer and output register.
//
// Multiplies two DIM x DIM signed Q16.16 matrices. Load transactions write one element of the
// left or right store; an unused action code is taken and dropped. A compute transaction emits
// DIM*DIM results in row-major order, the last one flagged; each result is the full-width dot
// product shifted right by 16 (floor) and saturated to 32 bits. Each result passes through DIM
// reads of the two stores (one element pair per cycle), a registered read, one multiply stage
// and the final accumulate into the output register; a new result starts only when the last is
// done. Input is stalled while a compute runs. Store entries must be written before a compute
// reads them.
`default_nettype none
module square_matrix_multiply #(
  parameter int DIM = sqmm_pkg::DIM_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        action,
  input  wire logic [sqmm_pkg::INDEX_W-1:0]      row_index,
  input  wire logic [sqmm_pkg::INDEX_W-1:0]      col_index,
  input  wire logic signed [sqmm_pkg::DATA_W-1:0] element_value,
  // output channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [sqmm_pkg::INDEX_W-1:0]           out_row,
  output logic [sqmm_pkg::INDEX_W-1:0]           out_col,
  output logic signed [sqmm_pkg::DATA_W-1:0]     product_value,
  output logic                                   last_of_run
);

  localparam int IDX_W   = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int ADR_W   = 2 * IDX_W;
  localparam int DEPTH   = 1 << ADR_W;
  localparam int EXT_W   = IDX_W + sqmm_pkg::INDEX_W;
  localparam int PROD_W  = 2 * sqmm_pkg::DATA_W;
  localparam int ACC_W   = PROD_W + IDX_W + 1;
  localparam int TOP_LSB = sqmm_pkg::FRAC_W + sqmm_pkg::DATA_W - 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIM - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  // element stores
  logic [sqmm_pkg::DATA_W-1:0] left_mem  [DEPTH];
  logic [sqmm_pkg::DATA_W-1:0] right_mem [DEPTH];

  logic             state;
  logic [IDX_W-1:0] row_cnt;
  logic [IDX_W-1:0] col_cnt;
  logic [IDX_W-1:0] k_cnt;
  logic             issuing;
  logic             entry_busy;

  logic                               rd_valid, rd_first, rd_last;
  logic signed [sqmm_pkg::DATA_W-1:0] left_rd, right_rd;
  logic                               mul_valid, mul_first, mul_last;
  logic signed [PROD_W-1:0]           prod;
  logic signed [ACC_W-1:0]            acc;
  logic signed [ACC_W-1:0]            acc_sum;
  logic [ACC_W-TOP_LSB-1:0]           sum_top;
  logic [sqmm_pkg::DATA_W-1:0]        sat_value;

  logic             in_take;
  logic [EXT_W-1:0] row_ext, col_ext;
  logic             load_in_range;
  logic [ADR_W-1:0] load_addr;
  logic             start_entry;
  logic             result_done;
  logic             last_entry;
  logic [EXT_W-1:0] row_out_ext, col_out_ext;

  // accept input only between computes
  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;

  // decode load address and range
  assign row_ext       = {{IDX_W{1'b0}}, row_index};
  assign col_ext       = {{IDX_W{1'b0}}, col_index};
  assign load_in_range = (row_ext < EXT_W'(DIM)) && (col_ext < EXT_W'(DIM));
  assign load_addr     = {row_ext[IDX_W-1:0], col_ext[IDX_W-1:0]};

  // write the stores
  always_ff @(posedge clk) begin
    if (in_take && load_in_range) begin
      if (action == sqmm_pkg::ACT_LOAD_LEFT) begin
        left_mem[load_addr] <= element_value;
      end
      if (action == sqmm_pkg::ACT_LOAD_RIGHT) begin
        right_mem[load_addr] <= element_value;
      end
    end
  end

  // read one element pair per issue cycle
  always_ff @(posedge clk) begin
    if (issuing) begin
      left_rd  <= left_mem[{row_cnt, k_cnt}];
      right_rd <= right_mem[{k_cnt, col_cnt}];
    end
  end

  // start an entry once the output register is free or draining
  assign start_entry = (state == ST_RUN) && !entry_busy && (!out_valid || !out_stall);
  assign result_done = mul_valid && mul_last;
  assign last_entry  = (row_cnt == LAST_IDX) && (col_cnt == LAST_IDX);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      row_cnt    <= '0;
      col_cnt    <= '0;
      k_cnt      <= '0;
      issuing    <= 1'b0;
      entry_busy <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_take && action == sqmm_pkg::ACT_COMPUTE) begin
            state   <= ST_RUN;
            row_cnt <= '0;
            col_cnt <= '0;
          end
        end
        ST_RUN: begin
          if (start_entry) begin
            entry_busy <= 1'b1;
            issuing    <= 1'b1;
            k_cnt      <= '0;
          end
          if (issuing) begin
            k_cnt <= k_cnt + IDX_W'(1);
            if (k_cnt == LAST_IDX) begin
              issuing <= 1'b0;
            end
          end
          if (result_done) begin
            entry_busy <= 1'b0;
            if (col_cnt == LAST_IDX) begin
              col_cnt <= '0;
              row_cnt <= row_cnt + IDX_W'(1);
            end else begin
              col_cnt <= col_cnt + IDX_W'(1);
            end
            if (last_entry) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // advance the pipeline valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      mul_valid <= 1'b0;
    end else begin
      rd_valid  <= issuing;
      mul_valid <= rd_valid;
    end
  end

  // carry first and last markers along with the data
  always_ff @(posedge clk) begin
    rd_first  <= (k_cnt == '0);
    rd_last   <= (k_cnt == LAST_IDX);
    mul_first <= rd_first;
    mul_last  <= rd_last;
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (rd_valid) begin
      prod <= left_rd * right_rd;
    end
  end

  // accumulate at full width
  assign acc_sum = (mul_first ? '0 : acc) + ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (mul_valid) begin
      acc <= acc_sum;
    end
  end

  // floor shift by the fraction width and saturate
  assign sum_top = acc_sum[ACC_W-1:TOP_LSB];
  always_comb begin
    if ((&sum_top) || !(|sum_top)) begin
      sat_value = acc_sum[TOP_LSB:sqmm_pkg::FRAC_W];
    end else if (acc_sum[ACC_W-1]) begin
      sat_value = {1'b1, {(sqmm_pkg::DATA_W-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(sqmm_pkg::DATA_W-1){1'b1}}};
    end
  end

  assign row_out_ext = {{sqmm_pkg::INDEX_W{1'b0}}, row_cnt};
  assign col_out_ext = {{sqmm_pkg::INDEX_W{1'b0}}, col_cnt};

  // output register: hold while stalled, load a finished entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_done) begin
      out_row       <= row_out_ext[sqmm_pkg::INDEX_W-1:0];
      out_col       <= col_out_ext[sqmm_pkg::INDEX_W-1:0];
      product_value <= sat_value;
      last_of_run   <= last_entry;
    end
  end

endmodule
`default_nettype wire
